// ===== sv/rpc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the red pixel centroid block
// Pixel and flag types, configuration register indexes and reset values,
// and the size of the queue between the front and back parts.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int PIX_W     = 8;
  localparam int CENT_W    = 11;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  typedef struct packed {
    logic frame_done;
    logic is_red;
  } flags_t;

endpackage

// ===== sv/rpc_front.sv =====
// ----------------------------------------------------------------------------
// rpc_front: pixel classification and position tracking
// Holds the frame size registers, tracks column and row, classes each pixel,
// keeps the running sums and count, and pushes one request per pixel.
// ----------------------------------------------------------------------------
module rpc_front #(
  parameter int MAX_DIM = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rpc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [rpc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  rpc_pkg::pix_t                       in_pix_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output rpc_pkg::pix_t                       q_pix_o,
  output rpc_pkg::flags_t                     q_flags_o,
  output logic [3*$clog2(MAX_DIM)-1:0]        q_sum_x_o,
  output logic [3*$clog2(MAX_DIM)-1:0]        q_sum_y_o,
  output logic [2*$clog2(MAX_DIM):0]          q_count_o
);

  localparam int CW = $clog2(MAX_DIM);
  localparam int SW = 3 * CW;
  localparam int NW = 2 * CW + 1;
  localparam int EW = ((CW > rpc_pkg::CFG_W) ? CW : rpc_pkg::CFG_W) + 1;

  logic [rpc_pkg::CFG_W-1:0] width_q, height_q;
  logic [CW-1:0]             col_q, row_q;
  logic [SW-1:0]             sum_x_q, sum_y_q;
  logic [NW-1:0]             count_q;

  logic [EW-1:0] w_ext, h_ext, w_eff, h_eff;
  logic          hit, line_end, last, accept;
  logic [SW-1:0] sum_x_d, sum_y_d;
  logic [NW-1:0] count_d;

  always_comb begin
    w_ext = EW'(width_q);
    h_ext = EW'(height_q);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_DIM)) begin
      w_eff = EW'(MAX_DIM);
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = EW'(1);
    end else if (h_ext > EW'(MAX_DIM)) begin
      h_eff = EW'(MAX_DIM);
    end else begin
      h_eff = h_ext;
    end
  end

  assign hit = ({in_pix_i.blue, 1'b0} < {1'b0, in_pix_i.red}) &&
               ({in_pix_i.green, 1'b0} < {1'b0, in_pix_i.red});
  assign line_end = EW'(col_q) >= (w_eff - EW'(1));
  assign last     = line_end && (EW'(row_q) >= (h_eff - EW'(1)));

  assign sum_x_d = sum_x_q + (hit ? SW'(col_q) : '0);
  assign sum_y_d = sum_y_q + (hit ? SW'(row_q) : '0);
  assign count_d = count_q + NW'(hit);

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  assign q_pix_o              = hit ? '0 : in_pix_i;
  assign q_flags_o.is_red     = hit;
  assign q_flags_o.frame_done = last;
  assign q_sum_x_o            = sum_x_d;
  assign q_sum_y_o            = sum_y_d;
  assign q_count_o            = count_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= rpc_pkg::RST_FRAME_WIDTH;
      height_q <= rpc_pkg::RST_FRAME_HEIGHT;
      col_q    <= '0;
      row_q    <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      count_q  <= NW'(1);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rpc_pkg::CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
          rpc_pkg::CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (last) begin
          col_q   <= '0;
          row_q   <= '0;
          sum_x_q <= '0;
          sum_y_q <= '0;
          count_q <= NW'(1);
        end else begin
          sum_x_q <= sum_x_d;
          sum_y_q <= sum_y_d;
          count_q <= count_d;
          if (line_end) begin
            col_q <= '0;
            row_q <= row_q + CW'(1);
          end else begin
            col_q <= col_q + CW'(1);
          end
        end
      end
    end
  end

  // The next frame starts from a clean position and empty sums.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last |=> col_q == '0 && row_q == '0 && sum_x_q == '0 &&
                       count_q == NW'(1))
    else $error("front state not cleared after the last pixel of a frame");

endmodule

// ===== sv/rpc_fifo.sv =====
// ----------------------------------------------------------------------------
// rpc_fifo: short request queue between front and back
// A small first-in first-out store that lets the front keep accepting
// pixels while the back works out a centroid.
// ----------------------------------------------------------------------------
module rpc_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0]       mem_q [rpc_pkg::QDEPTH];
  logic [rpc_pkg::QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [rpc_pkg::QAW:0]   count_q;
  logic                    do_push, do_pop;

  assign full_o     = count_q == (rpc_pkg::QAW+1)'(rpc_pkg::QDEPTH);
  assign empty_o    = count_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + rpc_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + rpc_pkg::QAW'(1);
      end
      count_q <= count_q + (rpc_pkg::QAW+1)'(do_push) - (rpc_pkg::QAW+1)'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (rpc_pkg::QAW+1)'(rpc_pkg::QDEPTH))
    else $error("queue fill count beyond its depth");

endmodule

// ===== sv/rpc_back.sv =====
// ----------------------------------------------------------------------------
// rpc_back: result stage with centroid divider
// Passes ordinary pixels to the output register and, on the last pixel of a
// frame, divides both sums by the count one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpc_back #(
  parameter int MAX_DIM = 2048
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_empty_i,
  output logic                                q_pop_o,
  input  rpc_pkg::pix_t                       q_pix_i,
  input  rpc_pkg::flags_t                     q_flags_i,
  input  logic [3*$clog2(MAX_DIM)-1:0]        q_sum_x_i,
  input  logic [3*$clog2(MAX_DIM)-1:0]        q_sum_y_i,
  input  logic [2*$clog2(MAX_DIM):0]          q_count_i,
  output logic                                m_valid_o,
  input  logic                                m_ready_i,
  output rpc_pkg::pix_t                       m_pix_o,
  output rpc_pkg::flags_t                     m_flags_o,
  output logic [rpc_pkg::CENT_W-1:0]          m_cx_o,
  output logic [rpc_pkg::CENT_W-1:0]          m_cy_o
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int SW    = 3 * CW;
  localparam int CNT_W = $clog2(CW);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_e;

  state_e                     state_q;
  logic                       out_valid_q;
  rpc_pkg::pix_t              out_pix_q, hold_pix_q;
  rpc_pkg::flags_t            out_flags_q, hold_flags_q;
  logic [rpc_pkg::CENT_W-1:0] cx_q, cy_q;
  logic [SW-1:0]              rem_x_q, rem_y_q, dsh_q;
  logic [CW-1:0]              qx_q, qy_q;
  logic [CNT_W-1:0]           cnt_q;

  logic out_free, pop, ge_x, ge_y;

  assign out_free = !out_valid_q || m_ready_i;
  assign pop      = (state_q == S_IDLE) && !q_empty_i &&
                    (q_flags_i.frame_done || out_free);
  assign ge_x     = rem_x_q >= dsh_q;
  assign ge_y     = rem_y_q >= dsh_q;

  assign q_pop_o   = pop;
  assign m_valid_o = out_valid_q;
  assign m_pix_o   = out_pix_q;
  assign m_flags_o = out_flags_q;
  assign m_cx_o    = cx_q;
  assign m_cy_o    = cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      out_pix_q    <= '0;
      out_flags_q  <= '0;
      hold_pix_q   <= '0;
      hold_flags_q <= '0;
      cx_q         <= '0;
      cy_q         <= '0;
      rem_x_q      <= '0;
      rem_y_q      <= '0;
      dsh_q        <= '0;
      qx_q         <= '0;
      qy_q         <= '0;
      cnt_q        <= '0;
    end else begin
      if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop) begin
            if (q_flags_i.frame_done) begin
              hold_pix_q   <= q_pix_i;
              hold_flags_q <= q_flags_i;
              rem_x_q      <= q_sum_x_i;
              rem_y_q      <= q_sum_y_i;
              dsh_q        <= SW'(q_count_i) << (CW - 1);
              qx_q         <= '0;
              qy_q         <= '0;
              cnt_q        <= CNT_W'(CW - 1);
              state_q      <= S_DIV;
            end else begin
              out_valid_q <= 1'b1;
              out_pix_q   <= q_pix_i;
              out_flags_q <= q_flags_i;
              cx_q        <= '0;
              cy_q        <= '0;
            end
          end
        end
        S_DIV: begin
          rem_x_q <= ge_x ? rem_x_q - dsh_q : rem_x_q;
          rem_y_q <= ge_y ? rem_y_q - dsh_q : rem_y_q;
          qx_q    <= {qx_q[CW-2:0], ge_x};
          qy_q    <= {qy_q[CW-2:0], ge_y};
          dsh_q   <= dsh_q >> 1;
          cnt_q   <= cnt_q - CNT_W'(1);
          if (cnt_q == '0) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_pix_q   <= hold_pix_q;
            out_flags_q <= hold_flags_q;
            cx_q        <= rpc_pkg::CENT_W'(qx_q);
            cy_q        <= rpc_pkg::CENT_W'(qy_q);
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_cent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_flags_q.frame_done |-> cx_q == '0 && cy_q == '0)
    else $error("centroid not zero on a pixel that does not end a frame");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV && cnt_q == '0 |=> state_q == S_DONE)
    else $error("divider did not finish after its last step");

  a_div_no_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != S_IDLE |-> !q_pop_o)
    else $error("queue popped while a centroid is being worked out");

endmodule

// ===== sv/red_pixel_centroid.sv =====
// ----------------------------------------------------------------------------
// red_pixel_centroid: red pixel masking and per-frame centroid
// Top level joining the front, the request queue and the back.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order, one per cycle when the stream allows. Each
// pixel gives one result: its channels, or zero when red outweighs twice
// blue and twice green, with the red flag on tuser. Ordinary pixels pass
// back to back while the output accepts them. The last pixel of a frame
// raises tlast and carries the centroid, which a restoring divider in the
// back works out one quotient bit per cycle. A four-entry queue lets the
// input go on being accepted meanwhile.
module red_pixel_centroid #(
  parameter int MAX_DIM = 2048
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rpc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [23:0]                   s_axis_tdata,  // blue, green, red
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [47:0]                   m_axis_tdata,  // out_blue, out_green,
                                                       // out_red, centroid_x,
                                                       // centroid_y
  output logic                          m_axis_tuser,  // is_red
  output logic                          m_axis_tlast
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int SW    = 3 * CW;
  localparam int NW    = 2 * CW + 1;
  localparam int PW    = $bits(rpc_pkg::pix_t);
  localparam int FW    = $bits(rpc_pkg::flags_t);
  localparam int REC_W = PW + FW + 2 * SW + NW;

  logic            q_push, q_pop, q_full, q_empty;
  rpc_pkg::pix_t   f_pix, b_pix, m_pix;
  rpc_pkg::flags_t f_flags, b_flags, m_flags;
  logic [SW-1:0]   f_sum_x, f_sum_y, b_sum_x, b_sum_y;
  logic [NW-1:0]   f_count, b_count;
  logic [REC_W-1:0] rec_in, rec_out;
  logic [rpc_pkg::CENT_W-1:0] m_cx, m_cy;

  rpc_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_pix_i   (rpc_pkg::pix_t'(s_axis_tdata)),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_pix_o    (f_pix),
    .q_flags_o  (f_flags),
    .q_sum_x_o  (f_sum_x),
    .q_sum_y_o  (f_sum_y),
    .q_count_o  (f_count)
  );

  assign rec_in = {f_count, f_sum_y, f_sum_x, f_flags, f_pix};
  assign {b_count, b_sum_y, b_sum_x, b_flags, b_pix} = rec_out;

  rpc_fifo #(
    .WIDTH(REC_W)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (rec_in),
    .pop_i       (q_pop),
    .pop_data_o  (rec_out),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  rpc_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_pop_o   (q_pop),
    .q_pix_i   (b_pix),
    .q_flags_i (b_flags),
    .q_sum_x_i (b_sum_x),
    .q_sum_y_i (b_sum_y),
    .q_count_i (b_count),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_pix_o   (m_pix),
    .m_flags_o (m_flags),
    .m_cx_o    (m_cx),
    .m_cy_o    (m_cy)
  );

  assign m_axis_tdata = {2'b00, m_cy, m_cx, m_pix};
  assign m_axis_tuser = m_flags.is_red;
  assign m_axis_tlast = m_flags.frame_done;

endmodule
